// ----- design/tifa_pkg.sv -----
package tifa_pkg;

  localparam int TAG_W       = 8;
  localparam int SMP_W       = 16;
  localparam int KIND_LSB    = 3;
  localparam int KIND_W      = TAG_W - KIND_LSB;
  localparam int CFG_DATA_W  = 40;
  localparam int CFG_SCALE_W = 20;
  localparam int OFF_W       = 40;
  localparam int OUT_W       = 41;
  localparam int CNT_OUT_W   = 7;
  localparam int REG_IDX_W   = 3;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_W      = 2;
  localparam int NUM_KINDS   = 2;

  localparam logic [KIND_W-1:0] TAG_KIND_GYRO  = 5'h01;
  localparam logic [KIND_W-1:0] TAG_KIND_ACCEL = 5'h02;

  localparam logic SENSOR_ACCEL = 1'b0;
  localparam logic SENSOR_GYRO  = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_Z;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACCEL_SCALE = 3'd0,
    REG_GYRO_SCALE  = 3'd1,
    REG_ACCEL_OFF_X = 3'd2,
    REG_ACCEL_OFF_Y = 3'd3,
    REG_ACCEL_OFF_Z = 3'd4,
    REG_GYRO_OFF_X  = 3'd5,
    REG_GYRO_OFF_Y  = 3'd6,
    REG_GYRO_OFF_Z  = 3'd7
  } tifa_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } tifa_state_e;

  typedef struct packed {
    logic              take;
    logic              clear;
    logic              sel_gyro;
    logic [AXIS_W-1:0] axis;
  } tifa_acc_ctrl_t;

endpackage

// ----- design/tifa_accum.sv -----
module tifa_accum import tifa_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int CNT_W       = 7,
  parameter int SUM_W       = 23
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tifa_acc_ctrl_t          ctrl_i,
  input  logic [TAG_W-1:0]        entry_tag_i,
  input  logic signed [SMP_W-1:0] sample_x_i,
  input  logic signed [SMP_W-1:0] sample_y_i,
  input  logic signed [SMP_W-1:0] sample_z_i,
  output logic signed [SUM_W-1:0] sum_o,
  output logic [CNT_W-1:0]        cnt_o,
  output logic                    bad_o
);

  logic signed [SUM_W-1:0] asum_q [NUM_AXES];
  logic signed [SUM_W-1:0] asum_d [NUM_AXES];
  logic signed [SUM_W-1:0] gsum_q [NUM_AXES];
  logic signed [SUM_W-1:0] gsum_d [NUM_AXES];
  logic [CNT_W-1:0]        acnt_q, acnt_d;
  logic [CNT_W-1:0]        gcnt_q, gcnt_d;
  logic [CNT_W-1:0]        seen_q, seen_d;
  logic                    bad_q, bad_d;
  logic signed [SMP_W-1:0] smp [NUM_AXES];
  logic [KIND_W-1:0]       kind;
  logic                    room;

  assign smp[0] = sample_x_i;
  assign smp[1] = sample_y_i;
  assign smp[2] = sample_z_i;
  assign kind   = entry_tag_i[TAG_W-1:KIND_LSB];
  assign room   = seen_q < CNT_W'(MAX_ENTRIES);

  always_comb begin
    asum_d = asum_q;
    gsum_d = gsum_q;
    acnt_d = acnt_q;
    gcnt_d = gcnt_q;
    seen_d = seen_q;
    bad_d  = bad_q;
    if (ctrl_i.clear) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        asum_d[i] = '0;
        gsum_d[i] = '0;
      end
      acnt_d = '0;
      gcnt_d = '0;
      seen_d = '0;
      bad_d  = 1'b0;
    end else if (ctrl_i.take && room) begin
      seen_d = seen_q + CNT_W'(1);
      case (kind)
        TAG_KIND_GYRO: begin
          gcnt_d = gcnt_q + CNT_W'(1);
          for (int i = 0; i < NUM_AXES; i++) begin
            gsum_d[i] = gsum_q[i] + SUM_W'(smp[i]);
          end
        end
        TAG_KIND_ACCEL: begin
          acnt_d = acnt_q + CNT_W'(1);
          for (int i = 0; i < NUM_AXES; i++) begin
            asum_d[i] = asum_q[i] + SUM_W'(smp[i]);
          end
        end
        default: begin
          bad_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        asum_q[i] <= '0;
        gsum_q[i] <= '0;
      end
      acnt_q <= '0;
      gcnt_q <= '0;
      seen_q <= '0;
      bad_q  <= 1'b0;
    end else begin
      asum_q <= asum_d;
      gsum_q <= gsum_d;
      acnt_q <= acnt_d;
      gcnt_q <= gcnt_d;
      seen_q <= seen_d;
      bad_q  <= bad_d;
    end
  end

  assign sum_o = ctrl_i.sel_gyro ? gsum_q[ctrl_i.axis] : asum_q[ctrl_i.axis];
  assign cnt_o = ctrl_i.sel_gyro ? gcnt_q : acnt_q;
  assign bad_o = bad_q;

endmodule

// ----- design/tifa_divider.sv -----
module tifa_divider import tifa_pkg::*; #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_nx;
  logic              fits;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVD_W-1];
      quo_q <= dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_nx[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ----- design/tifa_scaler.sv -----
module tifa_scaler import tifa_pkg::*; #(
  parameter int AVG_W = 23,
  parameter int SC_W  = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AVG_W-1:0] avg_i,
  input  logic [SC_W-1:0]         scale_i,
  input  logic signed [OFF_W-1:0] offset_i,
  output logic                    done_o,
  output logic [OUT_W-1:0]        result_o
);

  localparam int PROD_W = AVG_W + SC_W + 1;
  localparam int MAX_W  = (PROD_W > OFF_W) ? PROD_W : OFF_W;
  localparam int WIDE_W = (MAX_W + 1 > OUT_W) ? MAX_W + 1 : OUT_W;

  logic                     mul_q;
  logic                     done_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [OFF_W-1:0]  off_q;
  logic signed [WIDE_W-1:0] diff;
  logic [OUT_W-1:0]         res_q;
  logic signed [SC_W:0]     scl_s;

  assign scl_s  = {1'b0, scale_i};
  assign prod_d = PROD_W'(avg_i) * PROD_W'(scl_s);
  assign diff   = WIDE_W'(prod_q) - WIDE_W'(off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      done_q <= mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
      off_q  <= offset_i;
    end
    if (mul_q) begin
      res_q <= diff[OUT_W-1:0];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- design/tagged_imu_fifo_averager_unit.sv -----
// Non-final item: taken while idle; the block stays ready for the next item.
// Burst end: six axis passes (load, divide, scale) share one divider and one
// multiplier (SUM_W = 16 + clog2(MAX_ENTRIES + 1)); an empty kind skips the divider;
// the accel result is offered first, the gyro result after the accel result is taken.
// Input is not taken while a burst is being worked out or its results wait.
// Reset clears sums, counts, flags and all configuration registers at once.
module tagged_imu_fifo_averager_unit import tifa_pkg::*; #(
  parameter int MAX_ENTRIES     = 64,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [REG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [TAG_W-1:0]             entry_tag_i,
  input  logic signed [SMP_W-1:0]      sample_x_i,
  input  logic signed [SMP_W-1:0]      sample_y_i,
  input  logic signed [SMP_W-1:0]      sample_z_i,
  input  logic                         burst_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         sensor_kind_o,
  output logic [CNT_OUT_W-1:0]         entry_count_o,
  output logic                         valid_res_o,
  output logic signed [OUT_W-1:0]      out_x_o,
  output logic signed [OUT_W-1:0]      out_y_o,
  output logic signed [OUT_W-1:0]      out_z_o,
  output logic                         bad_tag_seen_o,
  output logic                         last_result_o
);

  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W     = SMP_W + CNT_W;
  localparam int SCALE_RAW = 4 + SCALE_FRAC_BITS;
  localparam int SC_W      = (SCALE_RAW < CFG_SCALE_W) ? SCALE_RAW : CFG_SCALE_W;

  tifa_state_e             state_q, state_d;
  logic                    kind_q, kind_d;
  logic [AXIS_W-1:0]       axis_q, axis_d;
  logic [SC_W-1:0]         scale_q [NUM_KINDS];
  logic signed [OFF_W-1:0] off_q   [NUM_KINDS][NUM_AXES];
  logic [OUT_W-1:0]        res_q   [NUM_AXES];

  tifa_acc_ctrl_t          acc_ctrl;
  logic signed [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0]        acc_cnt;
  logic                    acc_bad;
  logic                    cnt_zero;
  logic                    div_start, div_busy, div_done;
  logic signed [SUM_W-1:0] div_quot;
  logic signed [SUM_W-1:0] avg;
  logic                    scl_start, scl_done;
  logic [OUT_W-1:0]        scl_res;
  logic                    res_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KINDS; k++) begin
        scale_q[k] <= '0;
        for (int a = 0; a < NUM_AXES; a++) begin
          off_q[k][a] <= '0;
        end
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACCEL_SCALE: scale_q[SENSOR_ACCEL] <= cfg_data_i[SC_W-1:0];
        REG_GYRO_SCALE:  scale_q[SENSOR_GYRO]  <= cfg_data_i[SC_W-1:0];
        REG_ACCEL_OFF_X: off_q[SENSOR_ACCEL][AXIS_X] <= cfg_data_i;
        REG_ACCEL_OFF_Y: off_q[SENSOR_ACCEL][AXIS_Y] <= cfg_data_i;
        REG_ACCEL_OFF_Z: off_q[SENSOR_ACCEL][AXIS_Z] <= cfg_data_i;
        REG_GYRO_OFF_X:  off_q[SENSOR_GYRO][AXIS_X]  <= cfg_data_i;
        REG_GYRO_OFF_Y:  off_q[SENSOR_GYRO][AXIS_Y]  <= cfg_data_i;
        REG_GYRO_OFF_Z:  off_q[SENSOR_GYRO][AXIS_Z]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tifa_accum #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .entry_tag_i(entry_tag_i),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .sample_z_i (sample_z_i),
    .sum_o      (acc_sum),
    .cnt_o      (acc_cnt),
    .bad_o      (acc_bad)
  );

  tifa_divider #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_sum),
    .divisor_i (acc_cnt),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  assign cnt_zero = (acc_cnt == '0);
  assign avg      = cnt_zero ? '0 : div_quot;

  tifa_scaler #(
    .AVG_W(SUM_W),
    .SC_W (SC_W)
  ) u_scaler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scl_start),
    .avg_i   (avg),
    .scale_i (scale_q[kind_q]),
    .offset_i(off_q[kind_q][axis_q]),
    .done_o  (scl_done),
    .result_o(scl_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= SENSOR_ACCEL;
      axis_q  <= AXIS_X;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    kind_d            = kind_q;
    axis_d            = axis_q;
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    div_start         = 1'b0;
    scl_start         = 1'b0;
    res_we            = 1'b0;
    acc_ctrl.take     = 1'b0;
    acc_ctrl.clear    = 1'b0;
    acc_ctrl.sel_gyro = kind_q;
    acc_ctrl.axis     = axis_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          acc_ctrl.take = 1'b1;
          if (burst_end_i) begin
            kind_d  = SENSOR_ACCEL;
            axis_d  = AXIS_X;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        div_start = !cnt_zero;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_zero || div_done) begin
          scl_start = 1'b1;
          state_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scl_done) begin
          res_we = 1'b1;
          if (axis_q == AXIS_LAST) begin
            state_d = ST_OUT;
          end else begin
            axis_d  = axis_q + AXIS_W'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (kind_q == SENSOR_GYRO) begin
            acc_ctrl.clear = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            kind_d  = SENSOR_GYRO;
            axis_d  = AXIS_X;
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_q[axis_q] <= scl_res;
    end
  end

  assign sensor_kind_o  = kind_q;
  assign entry_count_o  = CNT_OUT_W'(acc_cnt);
  assign valid_res_o    = !cnt_zero;
  assign out_x_o        = $signed(res_q[AXIS_X]);
  assign out_y_o        = $signed(res_q[AXIS_Y]);
  assign out_z_o        = $signed(res_q[AXIS_Z]);
  assign bad_tag_seen_o = acc_bad;
  assign last_result_o  = (kind_q == SENSOR_GYRO);

  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_scale_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_done |-> (state_q == ST_SCALE))
    else $error("scaler result arrived outside the scale step");

  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_result_o) |=> in_ready_o)
    else $error("block not ready after the final result of a burst");

endmodule
